### design/qrs_pkg.sv
package qrs_pkg;

  // Fraction bits of the Q16.16 result.
  localparam int OutFrac = 16;
  localparam int RootW   = 32;

  // Control that travels with each request through the cell chains.
  typedef struct packed {
    logic vld;  // a request sits in this stage
    logic ok;   // real roots exist (a nonzero, discriminant not negative)
  } qrs_ctl_t;

endpackage

### design/qrs_sqrt_cell.sv
// One digit of a restoring square root: takes the next bit pair of the radicand.
module qrs_sqrt_cell
  import qrs_pkg::*;
#(
  parameter int DW = 34,
  parameter int SW = 17,
  parameter int RW = 19,
  parameter int PW = 32,
  parameter int P  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qrs_ctl_t        ctl_i,
  input  logic [DW-1:0]   disc_i,
  input  logic [SW-1:0]   root_i,
  input  logic [RW-1:0]   rem_i,
  input  logic [PW-1:0]   pl_i,
  output qrs_ctl_t        ctl_o,
  output logic [DW-1:0]   disc_o,
  output logic [SW-1:0]   root_o,
  output logic [RW-1:0]   rem_o,
  output logic [PW-1:0]   pl_o
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;
  logic [RW-1:0] rem_d;
  logic [SW-1:0] root_d;
  qrs_ctl_t      ctl_q;
  logic [DW-1:0] disc_q;
  logic [SW-1:0] root_q;
  logic [RW-1:0] rem_q;
  logic [PW-1:0] pl_q;

  always_comb begin
    rem_sh = {rem_i, disc_i[2*P +: 2]};
    trial  = (RW+2)'({root_i, 2'b01});
    take   = rem_sh >= trial;
    rem_d  = take ? RW'(rem_sh - trial) : RW'(rem_sh);
    root_d = {root_i[SW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    disc_q <= disc_i;
    root_q <= root_d;
    rem_q  <= rem_d;
    pl_q   <= pl_i;
  end

  assign ctl_o  = ctl_q;
  assign disc_o = disc_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign pl_o   = pl_q;

endmodule

### design/qrs_div_cell.sv
// One quotient bit of two restoring divisions that share a divisor.
module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int MW  = 18,
  parameter int DNW = 17,
  parameter int QW  = 34,
  parameter int PW  = 2,
  parameter int K   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qrs_ctl_t         ctl_i,
  input  logic [DNW-1:0]   den_i,
  input  logic [MW-1:0]    dvd_p_i,
  input  logic [MW-1:0]    dvd_m_i,
  input  logic [DNW-1:0]   rem_p_i,
  input  logic [DNW-1:0]   rem_m_i,
  input  logic [QW-1:0]    q_p_i,
  input  logic [QW-1:0]    q_m_i,
  input  logic [PW-1:0]    pl_i,
  output qrs_ctl_t         ctl_o,
  output logic [DNW-1:0]   den_o,
  output logic [MW-1:0]    dvd_p_o,
  output logic [MW-1:0]    dvd_m_o,
  output logic [DNW-1:0]   rem_p_o,
  output logic [DNW-1:0]   rem_m_o,
  output logic [QW-1:0]    q_p_o,
  output logic [QW-1:0]    q_m_o,
  output logic [PW-1:0]    pl_o
);

  // Dividend is the magnitude shifted up by the output fraction bits.
  localparam int BitIdx = QW - 1 - K;

  logic           bit_p;
  logic           bit_m;
  logic [DNW:0]   sh_p;
  logic [DNW:0]   sh_m;
  logic           ge_p;
  logic           ge_m;
  qrs_ctl_t       ctl_q;
  logic [DNW-1:0] den_q;
  logic [MW-1:0]  dvd_p_q;
  logic [MW-1:0]  dvd_m_q;
  logic [DNW-1:0] rem_p_q;
  logic [DNW-1:0] rem_m_q;
  logic [QW-1:0]  q_p_q;
  logic [QW-1:0]  q_m_q;
  logic [PW-1:0]  pl_q;

  if (BitIdx >= OutFrac) begin : g_num
    assign bit_p = dvd_p_i[BitIdx-OutFrac];
    assign bit_m = dvd_m_i[BitIdx-OutFrac];
  end else begin : g_frac
    assign bit_p = 1'b0;
    assign bit_m = 1'b0;
  end

  always_comb begin
    sh_p = {rem_p_i, bit_p};
    sh_m = {rem_m_i, bit_m};
    ge_p = sh_p >= {1'b0, den_i};
    ge_m = sh_m >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_i;
    dvd_p_q <= dvd_p_i;
    dvd_m_q <= dvd_m_i;
    rem_p_q <= ge_p ? DNW'(sh_p - {1'b0, den_i}) : DNW'(sh_p);
    rem_m_q <= ge_m ? DNW'(sh_m - {1'b0, den_i}) : DNW'(sh_m);
    q_p_q   <= {q_p_i[QW-2:0], ge_p};
    q_m_q   <= {q_m_i[QW-2:0], ge_m};
    pl_q    <= pl_i;
  end

  assign ctl_o   = ctl_q;
  assign den_o   = den_q;
  assign dvd_p_o = dvd_p_q;
  assign dvd_m_o = dvd_m_q;
  assign rem_p_o = rem_p_q;
  assign rem_m_o = rem_m_q;
  assign q_p_o   = q_p_q;
  assign q_m_o   = q_m_q;
  assign pl_o    = pl_q;

endmodule

### design/quadratic_root_solver_core.sv
// Quadratic root solver. Give signed Q8.8 coefficients a, b, c with start_i;
// busy_o stays low, so a new request is taken every cycle. Each request gives
// exactly one result, shown for one cycle with done_o; the receiver cannot
// stall it, so it must take every result in that cycle. The pipeline is made
// of the two cell chains: one square root cell per root bit (COEF_WIDTH+1)
// and one divider cell per quotient bit (COEF_WIDTH+18), plus product,
// discriminant, numerator and output stages. Roots are Q16.16, truncated
// toward zero and clamped; roots_valid_o is low (roots zero) when a is zero
// or disc < 0.
module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                         done_o,
  output logic signed [RootW-1:0]      root_plus_o,
  output logic signed [RootW-1:0]      root_minus_o,
  output logic                         roots_valid_o,
  output logic                         saturated_o
);

  localparam int W   = COEF_WIDTH;
  localparam int DW  = 2*W + 2;          // discriminant
  localparam int SW  = W + 1;            // square root
  localparam int RW  = SW + 2;           // root remainder
  localparam int NW  = W + 3;            // signed numerator
  localparam int MW  = W + 2;            // numerator magnitude
  localparam int DNW = W + 1;            // divisor |2a|
  localparam int QW  = MW + OutFrac;     // quotient bits
  localparam int QX  = (QW > 33) ? QW : 33;
  localparam int SPW = 2*W;              // a and b ride the root chain

  // ---- stage 1: magnitudes and products ----
  logic [W-1:0]   mag_a, mag_b, mag_c;
  qrs_ctl_t       s1_ctl_q;
  logic [2*W-1:0] b2_q, ac_q;
  logic           acneg_q;
  logic [W-1:0]   a1_q, b1_q;

  assign busy_o = 1'b0;

  always_comb begin
    mag_a = coef_a_i[W-1] ? W'(-coef_a_i) : W'(coef_a_i);
    mag_b = coef_b_i[W-1] ? W'(-coef_b_i) : W'(coef_b_i);
    mag_c = coef_c_i[W-1] ? W'(-coef_c_i) : W'(coef_c_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q.vld <= start_i;
      s1_ctl_q.ok  <= coef_a_i != '0;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_q    <= (2*W)'(mag_b) * (2*W)'(mag_b);
    ac_q    <= (2*W)'(mag_a) * (2*W)'(mag_c);
    acneg_q <= coef_a_i[W-1] ^ coef_c_i[W-1];
    a1_q    <= coef_a_i;
    b1_q    <= coef_b_i;
  end

  // ---- stage 2: discriminant b*b - 4ac ----
  logic [DW-1:0] b2x, ac4, disc_d;
  logic          disc_ok;
  qrs_ctl_t      s2_ctl_q;
  logic [DW-1:0] disc_q;
  logic [SPW-1:0] s2_pl_q;

  always_comb begin
    b2x = DW'(b2_q);
    ac4 = {ac_q, 2'b00};
    disc_ok = 1'b1;
    if (ac_q == '0 || acneg_q) begin
      disc_d = b2x + ac4;
    end else begin
      disc_ok = ac4 <= b2x;
      disc_d  = b2x - ac4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q.vld <= s1_ctl_q.vld;
      s2_ctl_q.ok  <= s1_ctl_q.ok & disc_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    disc_q  <= disc_d;
    s2_pl_q <= {a1_q, b1_q};
  end

  // ---- square root chain, one cell per root bit, MSB pair first ----
  qrs_ctl_t       sq_ctl [SW+1];
  logic [DW-1:0]  sq_disc[SW+1];
  logic [SW-1:0]  sq_root[SW+1];
  logic [RW-1:0]  sq_rem [SW+1];
  logic [SPW-1:0] sq_pl  [SW+1];

  assign sq_ctl[0]  = s2_ctl_q;
  assign sq_disc[0] = disc_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_pl[0]   = s2_pl_q;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .DW(DW), .SW(SW), .RW(RW), .PW(SPW), .P(SW-1-i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (sq_ctl[i]),
      .disc_i(sq_disc[i]),
      .root_i(sq_root[i]),
      .rem_i (sq_rem[i]),
      .pl_i  (sq_pl[i]),
      .ctl_o (sq_ctl[i+1]),
      .disc_o(sq_disc[i+1]),
      .root_o(sq_root[i+1]),
      .rem_o (sq_rem[i+1]),
      .pl_o  (sq_pl[i+1])
    );
  end

  // ---- stage 3: numerators -b +/- s and divisor |2a| ----
  logic signed [NW-1:0] a3, b3, s3, num_p, num_m;
  logic [NW-1:0]  mag_p_w, mag_m_w;
  logic           a_neg;
  qrs_ctl_t       s3_ctl_q;
  logic [MW-1:0]  mag_p_q, mag_m_q;
  logic [DNW-1:0] den_q;
  logic [1:0]     s3_neg_q;

  always_comb begin
    a3    = NW'($signed(sq_pl[SW][SPW-1:W]));
    b3    = NW'($signed(sq_pl[SW][W-1:0]));
    s3    = $signed(NW'(sq_root[SW]));
    a_neg = a3 < 0;
    num_p = -b3 + s3;
    num_m = -b3 - s3;
    mag_p_w = num_p[NW-1] ? NW'(-num_p) : NW'(num_p);
    mag_m_w = num_m[NW-1] ? NW'(-num_m) : NW'(num_m);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
    end else begin
      s3_ctl_q <= sq_ctl[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_p_q  <= mag_p_w[MW-1:0];
    mag_m_q  <= mag_m_w[MW-1:0];
    den_q    <= a_neg ? DNW'(-a3) << 1 : DNW'(a3) << 1;
    s3_neg_q <= {num_p[NW-1] ^ a_neg, num_m[NW-1] ^ a_neg};
  end

  // ---- divider chain, both roots side by side, one quotient bit a cell ----
  qrs_ctl_t       dv_ctl  [QW+1];
  logic [DNW-1:0] dv_den  [QW+1];
  logic [MW-1:0]  dv_dp   [QW+1];
  logic [MW-1:0]  dv_dm   [QW+1];
  logic [DNW-1:0] dv_rp   [QW+1];
  logic [DNW-1:0] dv_rm   [QW+1];
  logic [QW-1:0]  dv_qp   [QW+1];
  logic [QW-1:0]  dv_qm   [QW+1];
  logic [1:0]     dv_pl   [QW+1];

  assign dv_ctl[0] = s3_ctl_q;
  assign dv_den[0] = den_q;
  assign dv_dp[0]  = mag_p_q;
  assign dv_dm[0]  = mag_m_q;
  assign dv_rp[0]  = '0;
  assign dv_rm[0]  = '0;
  assign dv_qp[0]  = '0;
  assign dv_qm[0]  = '0;
  assign dv_pl[0]  = s3_neg_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qrs_div_cell #(
      .MW(MW), .DNW(DNW), .QW(QW), .PW(2), .K(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (dv_ctl[k]),
      .den_i  (dv_den[k]),
      .dvd_p_i(dv_dp[k]),
      .dvd_m_i(dv_dm[k]),
      .rem_p_i(dv_rp[k]),
      .rem_m_i(dv_rm[k]),
      .q_p_i  (dv_qp[k]),
      .q_m_i  (dv_qm[k]),
      .pl_i   (dv_pl[k]),
      .ctl_o  (dv_ctl[k+1]),
      .den_o  (dv_den[k+1]),
      .dvd_p_o(dv_dp[k+1]),
      .dvd_m_o(dv_dm[k+1]),
      .rem_p_o(dv_rp[k+1]),
      .rem_m_o(dv_rm[k+1]),
      .q_p_o  (dv_qp[k+1]),
      .q_m_o  (dv_qm[k+1]),
      .pl_o   (dv_pl[k+1])
    );
  end

  // ---- output stage: sign, clamp, flags ----
  logic [QX-1:0]    qpx, qmx;
  logic [RootW-1:0] rp_w, rm_w;
  logic             cp, cm;
  qrs_ctl_t         out_ctl_q;
  logic [RootW-1:0] rp_q, rm_q;
  logic             sat_q;

  always_comb begin
    qpx = QX'(dv_qp[QW]);
    qmx = QX'(dv_qm[QW]);
    cp  = 1'b0;
    cm  = 1'b0;
    if (!dv_pl[QW][1]) begin
      cp   = qpx > QX'(33'h0_7FFF_FFFF);
      rp_w = cp ? 32'h7FFF_FFFF : qpx[RootW-1:0];
    end else begin
      cp   = qpx > QX'(33'h0_8000_0000);
      rp_w = cp ? 32'h8000_0000 : -qpx[RootW-1:0];
    end
    if (!dv_pl[QW][0]) begin
      cm   = qmx > QX'(33'h0_7FFF_FFFF);
      rm_w = cm ? 32'h7FFF_FFFF : qmx[RootW-1:0];
    end else begin
      cm   = qmx > QX'(33'h0_8000_0000);
      rm_w = cm ? 32'h8000_0000 : -qmx[RootW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else begin
      out_ctl_q <= dv_ctl[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q  <= dv_ctl[QW].ok ? rp_w : '0;
    rm_q  <= dv_ctl[QW].ok ? rm_w : '0;
    sat_q <= dv_ctl[QW].ok & (cp | cm);
  end

  assign done_o        = out_ctl_q.vld;
  assign roots_valid_o = out_ctl_q.ok;
  assign root_plus_o   = rp_q;
  assign root_minus_o  = rm_q;
  assign saturated_o   = sat_q;

endmodule

### verif/quadratic_root_solver_checker.sv
module quadratic_root_solver_checker
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  input  logic                         done_o,
  input  logic signed [RootW-1:0]      root_plus_o,
  input  logic signed [RootW-1:0]      root_minus_o,
  input  logic                         roots_valid_o,
  input  logic                         saturated_o,
  output int                           fail_count_o,
  output int                           roots_pending_o,
  output int                           roots_checked_o,
  output int                           real_roots_o,
  output int                           clipped_roots_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RootW-1:0] plus;
    logic signed [RootW-1:0] minus;
    logic                    real_ok;
    logic                    clip;
  } roots_t;

  roots_t expected_roots[$];

  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] rem, root, trial;
    rem  = '0;
    root = '0;
    for (int p = 63; p >= 0; p--) begin
      rem   = (rem << 2) | ((n >> (2 * p)) & 128'd3);
      root  = root << 1;
      trial = (root << 1) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 128'd1;
      end
    end
    return root;
  endfunction

  // Q16.16 quotient, truncated toward zero and clamped to 32 bits.
  function automatic logic signed [RootW-1:0] q16_divide(logic signed [127:0] num,
                                                         logic signed [127:0] den,
                                                         ref logic clip);
    logic         neg;
    logic [127:0] q;
    neg = (num < 0) != (den < 0);
    q   = ((num < 0 ? -num : num) << OutFrac) / (den < 0 ? -den : den);
    if (q == 0) return '0;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        clip = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      return q[RootW-1:0];
    end
    if (q > 128'h8000_0000) begin
      clip = 1'b1;
      return 32'sh8000_0000;
    end
    return -q[RootW-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [COEF_WIDTH-1:0] a,
                                             logic signed [COEF_WIDTH-1:0] b,
                                             logic signed [COEF_WIDTH-1:0] c);
    roots_t              r;
    logic signed [127:0] wa, wb, wc, disc, s;
    logic                clip;
    r    = '0;
    clip = 1'b0;
    wa   = a;
    wb   = b;
    wc   = c;
    disc = wb * wb - 4 * wa * wc;
    // zero a or negative discriminant: flagged, roots left at zero
    if (wa == 0 || disc < 0) return r;
    s         = floor_sqrt(disc);
    r.plus    = q16_divide(-wb + s, 2 * wa, clip);
    r.minus   = q16_divide(-wb - s, 2 * wa, clip);
    r.real_ok = 1'b1;
    r.clip    = clip;
    return r;
  endfunction

  assign roots_pending_o = expected_roots.size();

  always @(posedge clk_i or negedge rst_ni) begin
    roots_t exp_r;
    if (!rst_ni) begin
      expected_roots.delete();
      fail_count_o    <= 0;
      roots_checked_o <= 0;
      real_roots_o    <= 0;
      clipped_roots_o <= 0;
    end else begin
      if (done_o) begin
        if (expected_roots.size() == 0) begin
          if (fail_count_o < 10)
            $display("ERROR: result with no request outstanding at %0t", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_roots.pop_front();
          roots_checked_o <= roots_checked_o + 1;
          real_roots_o    <= real_roots_o + exp_r.real_ok;
          clipped_roots_o <= clipped_roots_o + exp_r.clip;
          if (root_plus_o !== exp_r.plus || root_minus_o !== exp_r.minus ||
              roots_valid_o !== exp_r.real_ok || saturated_o !== exp_r.clip) begin
            if (fail_count_o < 10)
              $display("ERROR: exp plus %h minus %h valid %b sat %b, got %h %h %b %b",
                       exp_r.plus, exp_r.minus, exp_r.real_ok, exp_r.clip,
                       root_plus_o, root_minus_o, roots_valid_o, saturated_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_o)
        expected_roots.push_back(solve_quadratic(coef_a_i, coef_b_i, coef_c_i));
    end
  end

endmodule

### verif/quadratic_root_solver_core_test.sv
module quadratic_root_solver_core_test;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = 16;
  localparam int LATENCY    = 2 * CW + 23;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 1030;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic signed [CW-1:0] coef_a_i = '0;
  logic signed [CW-1:0] coef_b_i = '0;
  logic signed [CW-1:0] coef_c_i = '0;
  logic                 done_o;
  logic signed [31:0]   root_plus_o, root_minus_o;
  logic                 roots_valid_o, saturated_o;
  int                   fail_count, roots_pending, roots_checked, real_roots, clipped_roots;
  int                   idle_cycles;

  always #5 clk_i = ~clk_i;

  quadratic_root_solver_core #(.COEF_WIDTH(CW)) dut (.*);

  quadratic_root_solver_checker #(.COEF_WIDTH(CW)) checker_i (
    .*,
    .fail_count_o   (fail_count),
    .roots_pending_o(roots_pending),
    .roots_checked_o(roots_checked),
    .real_roots_o   (real_roots),
    .clipped_roots_o(clipped_roots)
  );

  // Watchdog: any request or result taken resets the idle count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", roots_pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold start high across back-to-back requests; drop it only for a gap.
  task automatic send_request(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    logic signed [CW-1:0] a, b, c;
    int                   gap, mode;
    bit                   burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero a, negative disc, zero disc, extremes, clipping.
    send_request(16'sd0, 16'sd256, 16'sd256, 0);
    send_request(16'sd0, -16'sd32768, 16'sd32767, 0);
    send_request(16'sd256, 16'sd0, 16'sd256, 0);            // x^2 + 1
    send_request(16'sd256, 16'sd512, 16'sd256, 1);          // double root
    send_request(16'sd256, 16'sd0, -16'sd256, 0);           // +-1
    send_request(16'sd256, 16'sd0, 16'sd0, 2);
    send_request(16'sd1, 16'sd32767, 16'sd0, 0);            // near the clamp, no clip
    send_request(16'sd1, -16'sd32768, 16'sd0, 0);
    send_request(-16'sd1, 16'sd32767, 16'sd1, 0);
    send_request(-16'sd1, -16'sd32768, 16'sd32767, 3);
    send_request(-16'sd32768, -16'sd32768, 16'sd32767, 0);
    send_request(-16'sd32768, 16'sd32767, -16'sd32768, 0);  // negative disc
    send_request(16'sd32767, 16'sd32767, -16'sd32768, 0);
    send_request(16'sd32767, -16'sd32768, 16'sd32767, 0);
    send_request(-16'sd32768, 16'sd0, 16'sd32767, 0);
    send_request(16'sd32767, 16'sd1, -16'sd1, 7);
    send_request(-16'sd1, 16'sd0, 16'sd32767, 0);
    send_request(16'sd1, 16'sd0, -16'sd32768, 0);
    send_request(-16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_request(16'sd32767, 16'sd32767, 16'sd32767, 0);

    burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      // Pressure point: let the pipeline drain completely once.
      if (i == N_RANDOM / 2) begin
        start_i <= 1'b0;
        while (roots_pending != 0) @(posedge clk_i);
      end
      mode = $urandom_range(0, 9);
      a = CW'($urandom);
      b = CW'($urandom);
      c = CW'($urandom);
      case (mode)
        0: a = '0;
        1, 2: a = CW'(int'($urandom_range(0, 15)) - 8);             // tiny a, clipping
        3, 4, 5: c = (a < 0) ? $signed(CW'($urandom_range(0, 32767)))
                             : -$signed(CW'($urandom_range(0, 32767)));  // real roots
        6: begin
          a = CW'(int'($urandom_range(0, 1023)) - 512);
          b = CW'(int'($urandom_range(0, 4095)) - 2048);
          c = CW'(int'($urandom_range(0, 1023)) - 512);
        end
        default: ;
      endcase
      gap = burst ? 0 : $urandom_range(0, 7);
      send_request(a, b, c, gap);
    end
    start_i <= 1'b0;

    while (roots_pending != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("checked %0d coefficient sets: %0d with real roots, %0d clipped, %0d flagged",
             roots_checked, real_roots, clipped_roots, roots_checked - real_roots);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver_core.sv
verif/quadratic_root_solver_checker.sv
verif/quadratic_root_solver_core_test.sv
